[rtl/core/lbm_pkg.sv]
// Shared types, register codes and default sizes for the label boundary marker.
`default_nettype none

package lbm_pkg;

    // Default sizing handed to the top level parameters
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam int DEF_LABEL_BITS = 16;

    // Fixed field widths of the stream and configuration ports
    localparam int PIXEL_LABEL_W = 16;
    localparam int OUT_COORD_W   = 11;
    localparam int CFG_DIM_W     = 12;
    localparam int CFG_INDEX_W   = 1;

    localparam logic [CFG_DIM_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [CFG_DIM_W-1:0] FRAME_HEIGHT_RST = 12'd480;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } lbm_cfg_reg_t;

    typedef struct packed {
        logic [PIXEL_LABEL_W-1:0] pixel_label;
        logic                     flush;
    } lbm_in_t;

    typedef struct packed {
        logic                   is_boundary;
        logic [OUT_COORD_W-1:0] out_row;
        logic [OUT_COORD_W-1:0] out_col;
        logic                   frame_end;
    } lbm_out_t;

    // Per-transaction control from the raster sequencer to the judge
    typedef struct packed {
        logic                   emit;
        logic                   judge_bank;
        logic                   has_top;
        logic                   has_bottom;
        logic                   has_left;
        logic                   has_right;
        logic                   frame_end;
        logic [OUT_COORD_W-1:0] row;
        logic [OUT_COORD_W-1:0] col;
    } lbm_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/lbm_raster_ctrl.sv]
// Raster position counters, drain sequencing and line store addressing.
`default_nettype none

module lbm_raster_ctrl #(
    parameter int MAX_WIDTH  = lbm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lbm_pkg::DEF_MAX_HEIGHT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [lbm_pkg::CFG_DIM_W-1:0]      frame_width,
    input  logic [lbm_pkg::CFG_DIM_W-1:0]      frame_height,
    input  logic                               item_accept,
    input  logic                               item_flush,
    output lbm_pkg::lbm_ctrl_t                 item_ctrl,
    output logic                               advance,
    output logic                               wr_en,
    output logic                               wr_bank,
    output logic [$clog2(MAX_WIDTH)-1:0]       wr_col,
    output logic [$clog2(MAX_WIDTH)-1:0]       rd_col_a,
    output logic [$clog2(MAX_WIDTH)-1:0]       rd_col_b
);
    import lbm_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CW    = (COL_W + 1 > CFG_DIM_W) ? COL_W + 1 : CFG_DIM_W;
    localparam int RW    = (ROW_W + 1 > CFG_DIM_W) ? ROW_W + 1 : CFG_DIM_W;
    localparam logic [CW-1:0] W_MAX = CW'(MAX_WIDTH);
    localparam logic [RW-1:0] H_MAX = RW'(MAX_HEIGHT);

    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic             draining_reg, draining_next;

    logic [CW-1:0] w_ext, w_eff, col_ext, col_inc;
    logic [RW-1:0] h_ext, h_eff, row_ext, row_inc, row_m1, row_out;
    logic          col_last, row_last, pixel_go, flush_go;

    // Clamp the frame size to 1..max
    always_comb begin
        w_ext = CW'(frame_width);
        h_ext = RW'(frame_height);
        if (w_ext == '0) begin
            w_eff = CW'(1);
        end else if (w_ext > W_MAX) begin
            w_eff = W_MAX;
        end else begin
            w_eff = w_ext;
        end
        if (h_ext == '0) begin
            h_eff = RW'(1);
        end else if (h_ext > H_MAX) begin
            h_eff = H_MAX;
        end else begin
            h_eff = h_ext;
        end
    end

    assign col_ext  = CW'(col_reg);
    assign col_inc  = col_ext + CW'(1);
    assign col_last = (col_inc >= w_eff);
    assign row_ext  = RW'(row_reg);
    assign row_inc  = row_ext + RW'(1);
    assign row_m1   = row_ext - RW'(1);
    assign row_last = (row_inc >= h_eff);
    assign row_out  = draining_reg ? row_ext : row_m1;

    // Pixels are dropped while draining, flushes are dropped otherwise
    assign pixel_go = item_accept & ~item_flush & ~draining_reg;
    assign flush_go = item_accept & item_flush & draining_reg;

    // Next state
    always_comb begin
        row_next      = row_reg;
        col_next      = col_reg;
        draining_next = draining_reg;
        if (pixel_go) begin
            if (col_last) begin
                col_next = '0;
                if (row_last) begin
                    draining_next = 1'b1;
                end else begin
                    row_next = row_inc[ROW_W-1:0];
                end
            end else begin
                col_next = col_inc[COL_W-1:0];
            end
        end else if (flush_go) begin
            if (col_last) begin
                row_next      = '0;
                col_next      = '0;
                draining_next = 1'b0;
            end else begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    // Outputs
    always_comb begin
        item_ctrl.emit       = (pixel_go & (row_reg != '0)) | flush_go;
        item_ctrl.judge_bank = draining_reg ? row_reg[0] : ~row_reg[0];
        item_ctrl.has_top    = draining_reg ? (row_reg != '0) : (row_ext >= RW'(2));
        item_ctrl.has_bottom = ~draining_reg;
        item_ctrl.has_left   = (col_reg != '0);
        item_ctrl.has_right  = (col_inc < w_eff);
        item_ctrl.frame_end  = draining_reg & col_last;
        item_ctrl.row        = row_out[OUT_COORD_W-1:0];
        item_ctrl.col        = col_ext[OUT_COORD_W-1:0];

        advance  = pixel_go | flush_go;
        wr_en    = pixel_go;
        wr_bank  = row_reg[0];
        wr_col   = col_reg;
        // Prefetch the center column of the next transaction and its right neighbor
        rd_col_a = col_last ? '0 : col_inc[COL_W-1:0];
        rd_col_b = rd_col_a + COL_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg      <= '0;
            col_reg      <= '0;
            draining_reg <= 1'b0;
        end else begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            draining_reg <= draining_next;
        end
    end

`ifndef ASSERT_OFF
    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        flush_go && col_last |=> !draining_reg && row_reg == '0 && col_reg == '0)
        else $error("counters not cleared after last drained pixel");

    a_drain_start: assert property (@(posedge aclk) disable iff (!aresetn)
        pixel_go && col_last && row_last |=> draining_reg && col_reg == '0)
        else $error("drain not entered after last row");

    a_drain_col0: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(draining_reg) |-> col_reg == '0 && $past(pixel_go))
        else $error("drain started off a row end");
`endif

endmodule

`default_nettype wire

[rtl/core/lbm_line_store.sv]
// Two-bank line store indexed by column, two registered read ports with write bypass.
`default_nettype none

module lbm_line_store #(
    parameter int DEPTH  = lbm_pkg::DEF_MAX_WIDTH,
    parameter int DATA_W = lbm_pkg::DEF_LABEL_BITS
) (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic                         wr_bank,
    input  logic [$clog2(DEPTH)-1:0]     wr_col,
    input  logic [DATA_W-1:0]            wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(DEPTH)-1:0]     rd_col_a,
    input  logic [$clog2(DEPTH)-1:0]     rd_col_b,
    output logic [1:0][DATA_W-1:0]       rd_data_a,
    output logic [1:0][DATA_W-1:0]       rd_data_b
);
    import lbm_pkg::*;

    logic [DATA_W-1:0] bank0_mem [DEPTH];
    logic [DATA_W-1:0] bank1_mem [DEPTH];

    logic hit_a0, hit_a1, hit_b0, hit_b1;

    // A read of the entry being written sees the new label
    assign hit_a0 = wr_en & ~wr_bank & (wr_col == rd_col_a);
    assign hit_a1 = wr_en &  wr_bank & (wr_col == rd_col_a);
    assign hit_b0 = wr_en & ~wr_bank & (wr_col == rd_col_b);
    assign hit_b1 = wr_en &  wr_bank & (wr_col == rd_col_b);

    always_ff @(posedge aclk) begin
        if (wr_en && !wr_bank) begin
            bank0_mem[wr_col] <= wr_data;
        end
        if (wr_en && wr_bank) begin
            bank1_mem[wr_col] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a[0] <= hit_a0 ? wr_data : bank0_mem[rd_col_a];
            rd_data_a[1] <= hit_a1 ? wr_data : bank1_mem[rd_col_a];
            rd_data_b[0] <= hit_b0 ? wr_data : bank0_mem[rd_col_b];
            rd_data_b[1] <= hit_b1 ? wr_data : bank1_mem[rd_col_b];
        end
    end

endmodule

`default_nettype wire

[rtl/core/lbm_judge.sv]
// Neighbor window and four-neighbor boundary compare.
`default_nettype none

module lbm_judge #(
    parameter int DATA_W = lbm_pkg::DEF_LABEL_BITS
) (
    input  logic                   aclk,
    input  logic                   advance,
    input  lbm_pkg::lbm_ctrl_t     item_ctrl,
    input  logic [DATA_W-1:0]      bottom_label,
    input  logic [1:0][DATA_W-1:0] rd_data_a,
    input  logic [1:0][DATA_W-1:0] rd_data_b,
    output logic                   is_boundary
);
    import lbm_pkg::*;

    logic [DATA_W-1:0] left_reg;
    logic [DATA_W-1:0] center, top, right;
    logic              top_bank;

    assign top_bank = ~item_ctrl.judge_bank;
    assign center   = rd_data_a[item_ctrl.judge_bank];
    assign top      = rd_data_a[top_bank];
    assign right    = rd_data_b[item_ctrl.judge_bank];

    always_comb begin
        is_boundary = (item_ctrl.has_top    && (top          != center)) ||
                      (item_ctrl.has_bottom && (bottom_label != center)) ||
                      (item_ctrl.has_left   && (left_reg     != center)) ||
                      (item_ctrl.has_right  && (right        != center));
    end

    // Shift the center into the left slot for the next column
    always_ff @(posedge aclk) begin
        if (advance) begin
            left_reg <= center;
        end
    end

endmodule

`default_nettype wire

[rtl/core/label_boundary_marker_unit.sv]
// Top level of the label boundary marker: config registers, handshake and result register.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-----------------------------------
//  s_       | in        | s_valid / s_ready          | s_data: pixel_label, flush
//  m_       | out       | m_valid / m_ready          | m_data: is_boundary, out_row,
//           |           |                            |         out_col, frame_end
//  cfg_     | in        | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One transaction per clock unless stalled: the label, the prefetched line store columns
// and the window registers feed the compare, and the result lands in the output register
// in the cycle of acceptance. The line store's read ports are the only memory path.
// Reset (aresetn low, synchronous) clears the counters, the drain flag and the
// output valid, and loads width 640 and height 480; the line store is not cleared
// and needs no clearing pass. A stalled result blocks new input only while it waits;
// s_ready follows m_ready combinationally. cfg_ready is always high.
`default_nettype none

module label_boundary_marker_unit #(
    parameter int MAX_WIDTH  = lbm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lbm_pkg::DEF_MAX_HEIGHT,
    parameter int LABEL_BITS = lbm_pkg::DEF_LABEL_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  lbm_pkg::lbm_in_t                 s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output lbm_pkg::lbm_out_t                m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lbm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lbm_pkg::CFG_DIM_W-1:0]    cfg_data
);
    import lbm_pkg::*;

    // Labels wider than the input field carry no extra bits
    localparam int STORE_W = (LABEL_BITS < PIXEL_LABEL_W) ? LABEL_BITS : PIXEL_LABEL_W;
    localparam int COL_W   = $clog2(MAX_WIDTH);

    logic [CFG_DIM_W-1:0] frame_width_reg;
    logic [CFG_DIM_W-1:0] frame_height_reg;

    logic      m_valid_reg;
    lbm_out_t  m_data_reg;

    logic              item_accept;
    lbm_ctrl_t         item_ctrl;
    logic              advance, wr_en, wr_bank;
    logic [COL_W-1:0]  wr_col, rd_col_a, rd_col_b;
    logic [STORE_W-1:0] label;
    logic [1:0][STORE_W-1:0] rd_data_a, rd_data_b;
    logic              is_boundary;

    // Accept while the output register is empty or being drained this cycle
    assign s_ready     = ~m_valid_reg | m_ready;
    assign item_accept = s_valid & s_ready;
    assign label       = s_data.pixel_label[STORE_W-1:0];

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Configuration decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (lbm_cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
            endcase
        end
    end

    lbm_raster_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .item_accept  (item_accept),
        .item_flush   (s_data.flush),
        .item_ctrl    (item_ctrl),
        .advance      (advance),
        .wr_en        (wr_en),
        .wr_bank      (wr_bank),
        .wr_col       (wr_col),
        .rd_col_a     (rd_col_a),
        .rd_col_b     (rd_col_b)
    );

    // Two previous rows, one bank per row parity
    lbm_line_store #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (STORE_W)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_bank   (wr_bank),
        .wr_col    (wr_col),
        .wr_data   (label),
        .rd_en     (advance),
        .rd_col_a  (rd_col_a),
        .rd_col_b  (rd_col_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    lbm_judge #(
        .DATA_W (STORE_W)
    ) u_judge (
        .aclk         (aclk),
        .advance      (advance),
        .item_ctrl    (item_ctrl),
        .bottom_label (label),
        .rd_data_a    (rd_data_a),
        .rd_data_b    (rd_data_b),
        .is_boundary  (is_boundary)
    );

    // Output register: drop on take, load on a result-bearing transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (item_accept && item_ctrl.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_accept && item_ctrl.emit) begin
            m_data_reg.is_boundary <= is_boundary;
            m_data_reg.out_row     <= item_ctrl.row;
            m_data_reg.out_col     <= item_ctrl.col;
            m_data_reg.frame_end   <= item_ctrl.frame_end;
        end
    end

`ifndef ASSERT_OFF
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        item_accept && item_ctrl.emit |=> m_valid_reg)
        else $error("result of accepted transaction not presented");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !item_accept)
        else $error("input accepted over a stalled result");

    a_idle_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_ready && !(item_accept && item_ctrl.emit) |=> !m_valid_reg)
        else $error("taken result repeated");
`endif

endmodule

`default_nettype wire
